[rtl/core/bmhq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared widths, codes and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // field widths
    localparam int DATA_W        = 32;
    localparam int CAP_W         = 11;
    localparam int STATUS_W      = 2;
    localparam int DEFAULT_DEPTH = 1024;

    // capacity limit after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // operation codes
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // value returned by an extract from an empty heap
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

[rtl/core/bmhq_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_store
// Heap entry memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhq_store #(
    parameter int DEPTH = bmhq_pkg::DEFAULT_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [$clog2(DEPTH)-1:0]              waddr,
    input  logic signed [bmhq_pkg::DATA_W-1:0]    wdata,
    input  logic [$clog2(DEPTH)-1:0]              raddr_a,
    input  logic [$clog2(DEPTH)-1:0]              raddr_b,
    output logic signed [bmhq_pkg::DATA_W-1:0]    rdata_a,
    output logic signed [bmhq_pkg::DATA_W-1:0]    rdata_b
);
    import bmhq_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, registered read data
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/core/binary_min_heap_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Min-heap priority queue of signed words held in a two-read, one-write RAM.
// ----------------------------------------------------------------------------
// Done rises in the cycle after start for a dropped insert, an empty
// extract or an insert into an empty heap.
// Each operation moves one heap level per cycle, set by the single RAM write
// port that moves the hole; a new word may start in the cycle done is high.
// Results cannot be stalled: done is a one-cycle strobe.
// Reset clears the entry count and sets the capacity limit to 1024; RAM is
// left as is and only entries below the count are used.
module binary_min_heap_queue_core #(
    parameter int DEPTH = bmhq_pkg::DEFAULT_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  kind,
    input  logic signed [bmhq_pkg::DATA_W-1:0]    value,
    // result channel
    output logic                                  done,
    output logic signed [bmhq_pkg::DATA_W-1:0]    min_value,
    output logic [bmhq_pkg::STATUS_W-1:0]         status,
    output logic [$clog2(DEPTH+1)-1:0]            count,
    // configuration channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bmhq_pkg::CAP_W-1:0]            cfg_data
);
    import bmhq_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int IW    = AW + 2;
    localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_FIN,
        ST_EX_LOAD,
        ST_DN_CMP
    } state_t;

    state_t                   state_reg, state_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CAP_W-1:0]         cap_reg;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    // memory ports
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [AW-1:0]            raddr_a, raddr_b;
    logic signed [DATA_W-1:0] rd_a, rd_b;

    // index arithmetic
    logic                     full;
    logic [IW-1:0]            n_ext;
    logic [AW-1:0]            up_par;
    logic [IW-1:0]            cur_lc, cur_rc;
    logic                     l_ok, r_ok;
    logic                     go_l, go_r;
    logic signed [DATA_W-1:0] sel_val, child_val;
    logic [AW-1:0]            best_pos, cand_pos;
    logic [IW-1:0]            cand_lc, cand_rc;
    logic                     cand_has;

    bmhq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // full when the count reaches the limit or the store size
    assign full = (LW'(count_reg) >= LW'(cap_reg)) || (LW'(count_reg) >= LW'(DEPTH));

    // parent of the hole on the way up
    assign up_par = (pos_reg - 1'b1) >> 1;

    // children of the hole on the way down
    assign n_ext  = IW'(count_reg);
    assign cur_lc = {1'b0, pos_reg, 1'b1};
    assign cur_rc = cur_lc + 1'b1;
    assign l_ok   = cur_lc < n_ext;
    assign r_ok   = cur_rc < n_ext;

    // pick the smaller child, left wins a tie
    assign go_l      = l_ok && (rd_a < v_reg);
    assign sel_val   = go_l ? rd_a : v_reg;
    assign go_r      = r_ok && (rd_b < sel_val);
    assign best_pos  = go_r ? cur_rc[AW-1:0] : cur_lc[AW-1:0];
    assign child_val = go_r ? rd_b : rd_a;

    // children of the next hole position
    assign cand_pos = (state_reg == ST_EX_LOAD) ? '0 : best_pos;
    assign cand_lc  = {1'b0, cand_pos, 1'b1};
    assign cand_rc  = cand_lc + 1'b1;
    assign cand_has = cand_lc < n_ext;

    // sequencer next state and memory control
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        pos_next    = pos_reg;
        v_next      = v_reg;
        min_next    = min_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = v_reg;
        raddr_a     = '0;
        raddr_b     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        min_next = '0;
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            status_next = STATUS_OK;
                            count_next  = CNT_W'(count_reg + 1'b1);
                            if (count_reg == '0)
                            begin
                                we        = 1'b1;
                                waddr     = '0;
                                wdata     = value;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                v_next     = value;
                                pos_next   = count_reg[AW-1:0];
                                raddr_a    = (count_reg[AW-1:0] - 1'b1) >> 1;
                                state_next = ST_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            min_next    = EMPTY_VALUE;
                            status_next = STATUS_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            status_next = STATUS_OK;
                            count_next  = CNT_W'(count_reg - 1'b1);
                            raddr_a     = '0;
                            raddr_b     = AW'(count_reg - 1'b1);
                            state_next  = ST_EX_LOAD;
                        end
                    end
                end
            end

            ST_UP_CMP:
            begin
                we = 1'b1;
                if (v_reg < rd_a)
                begin
                    // parent moves down into the hole
                    wdata    = rd_a;
                    pos_next = up_par;
                    if (up_par == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        raddr_a = (up_par - 1'b1) >> 1;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FIN:
            begin
                we         = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_EX_LOAD:
            begin
                min_next = rd_a;
                v_next   = rd_b;
                pos_next = '0;
                if (count_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!cand_has)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = rd_b;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    raddr_a    = cand_lc[AW-1:0];
                    raddr_b    = cand_rc[AW-1:0];
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_CMP:
            begin
                we = 1'b1;
                if (go_l || go_r)
                begin
                    // smaller child moves up into the hole
                    wdata    = child_val;
                    pos_next = best_pos;
                    if (cand_has)
                    begin
                        raddr_a = cand_lc[AW-1:0];
                        raddr_b = cand_rc[AW-1:0];
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // hole position, carried value and result word
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        v_reg      <= v_next;
        min_reg    <= min_next;
        status_reg <= status_next;
    end

    // outputs
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign min_value = min_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign cfg_ready = 1'b1;

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while an operation is in flight");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(count_reg) <= LW'(DEPTH))
        else $error("entry count beyond store size");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_INSERT && full)
        |=> (done && status == STATUS_FULL && $stable(count_reg)))
        else $error("insert into full heap not dropped");

    a_empty_extract: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_EXTRACT && count_reg == '0)
        |=> (done && status == STATUS_EMPTY && min_value == EMPTY_VALUE))
        else $error("extract from empty heap mishandled");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (we && !busy) |-> (start && kind == KIND_INSERT && count_reg == '0))
        else $error("memory write outside an operation");

endmodule
